@@ src/qkc_pkg.sv @@
// qkc_pkg: shared types, constants and the step decode for the quadrature knob counter
// no dependencies; used by quadrature_knob_counter_top
`default_nettype none

package qkc_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 16;
	localparam int FIELD_WIDTH         = 16;
	localparam int CFG_INDEX_WIDTH     = 1;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 1'd1;

	// transition codes {prev_a, prev_b, a, b}
	localparam logic [3:0] CODE_UP_0   = 4'b1101;
	localparam logic [3:0] CODE_UP_1   = 4'b0100;
	localparam logic [3:0] CODE_UP_2   = 4'b0010;
	localparam logic [3:0] CODE_UP_3   = 4'b1011;
	localparam logic [3:0] CODE_DOWN_0 = 4'b1110;
	localparam logic [3:0] CODE_DOWN_1 = 4'b0111;
	localparam logic [3:0] CODE_DOWN_2 = 4'b0001;
	localparam logic [3:0] CODE_DOWN_3 = 4'b1000;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef struct packed {
		logic                           func;
		logic                           phase_a;
		logic                           phase_b;
		logic signed [FIELD_WIDTH-1:0]  load_value;
	} sample_t;

	typedef struct packed {
		logic                           changed;
		logic signed [FIELD_WIDTH-1:0]  count;
	} result_t;

	function automatic dir_t step_dir(input logic [3:0] code);
		dir_t d;
		unique case (code)
			CODE_UP_0, CODE_UP_1, CODE_UP_2, CODE_UP_3:         d = DIR_UP;
			CODE_DOWN_0, CODE_DOWN_1, CODE_DOWN_2, CODE_DOWN_3: d = DIR_DOWN;
			default:                                            d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ src/qkc_stream_if.sv @@
// qkc_stream_if: valid/ready channel carrying one payload beat
// payload type is set per instance, normally from qkc_pkg
`default_nettype none

interface qkc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/quadrature_knob_counter_top.sv @@
// quadrature_knob_counter_top: two-phase encoder decoder with a saturating up/down counter
// depends on qkc_pkg and qkc_stream_if
//
// Each sample beat carries both encoder pin levels, or a load value. The beat is
// registered, then the code {previous pins, current pins} is decoded and the counter
// is clamped to the configured range, stepped, saturated and written back together with
// the result register. A new beat is taken every cycle unless the result stalls; the
// result passes through the input register and then the result register, and a stalled
// result blocks new samples once both registers are full. The counter holds COUNT_WIDTH
// signed bits and count shows its low 16 bits. Range registers must be written through
// the cfg port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module quadrature_knob_counter_top #(
	parameter int COUNT_WIDTH = qkc_pkg::COUNT_WIDTH_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [qkc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [qkc_pkg::FIELD_WIDTH-1:0]      cfg_wr_data,
	qkc_stream_if.sink                                sample,
	qkc_stream_if.source                              result
);

	localparam int FW = qkc_pkg::FIELD_WIDTH;
	localparam int EW = ((COUNT_WIDTH > FW) ? COUNT_WIDTH : FW) + 2;
	localparam logic signed [EW-1:0] FIT_TOP = EW'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] FIT_BOT = -FIT_TOP - EW'(1);

	logic signed [FW-1:0]          range_low_q;
	logic signed [FW-1:0]          range_high_q;
	logic [1:0]                    prev_q;
	logic signed [COUNT_WIDTH-1:0] counter_q;

	qkc_pkg::sample_t              item_s1;
	logic                          item_valid_s1;
	qkc_pkg::result_t              result_s2;
	logic                          result_valid_s2;

	logic                          advance;
	qkc_pkg::dir_t                 dir;
	logic signed [EW-1:0]          low_ext;
	logic signed [EW-1:0]          high_ext;
	logic signed [EW-1:0]          base;
	logic signed [EW-1:0]          clamped;
	logic signed [EW-1:0]          stepped;
	logic signed [EW-1:0]          fitted;
	logic                          changed;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				qkc_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wr_data;
				qkc_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign advance      = item_valid_s1 && (!result_valid_s2 || result.ready);
	assign sample.ready = !item_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			item_valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			item_s1 <= sample.data;
		end
	end

	// decode, clamp, step, saturate
	always_comb begin
		dir      = qkc_pkg::step_dir({prev_q, item_s1.phase_a, item_s1.phase_b});
		low_ext  = {{(EW-FW){range_low_q[FW-1]}}, range_low_q};
		high_ext = {{(EW-FW){range_high_q[FW-1]}}, range_high_q};
		if (item_s1.func == qkc_pkg::FUNC_LOAD) begin
			base = {{(EW-FW){item_s1.load_value[FW-1]}}, item_s1.load_value};
		end else begin
			base = {{(EW-COUNT_WIDTH){counter_q[COUNT_WIDTH-1]}}, counter_q};
		end
		priority if (base < low_ext) begin
			clamped = low_ext;
		end else if (base > high_ext) begin
			clamped = high_ext;
		end else begin
			clamped = base;
		end
		stepped = clamped;
		changed = 1'b0;
		if (item_s1.func == qkc_pkg::FUNC_SAMPLE) begin
			unique case (dir)
				qkc_pkg::DIR_UP: begin
					changed = 1'b1;
					stepped = ((clamped + EW'(1)) > high_ext) ? high_ext : clamped + EW'(1);
				end
				qkc_pkg::DIR_DOWN: begin
					changed = 1'b1;
					stepped = ((clamped - EW'(1)) < low_ext) ? low_ext : clamped - EW'(1);
				end
				default: ;
			endcase
		end
		priority if (stepped < FIT_BOT) begin
			fitted = FIT_BOT;
		end else if (stepped > FIT_TOP) begin
			fitted = FIT_TOP;
		end else begin
			fitted = stepped;
		end
	end

	// counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			prev_q    <= '0;
		end else if (advance) begin
			counter_q <= fitted[COUNT_WIDTH-1:0];
			if (item_s1.func == qkc_pkg::FUNC_SAMPLE) begin
				prev_q <= {item_s1.phase_a, item_s1.phase_b};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.changed <= changed;
			result_s2.count   <= fitted[FW-1:0];
		end
	end

	assign result.valid = result_valid_s2;
	assign result.data  = result_s2;

	// checks
	a_load_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == qkc_pkg::FUNC_LOAD |=> !result_s2.changed)
		else $error("load beat reported a step");

	a_step_moves_pins: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == qkc_pkg::FUNC_SAMPLE && dir != qkc_pkg::DIR_NONE
		|=> prev_q != $past(prev_q))
		else $error("step decoded without a pin change");

	a_load_keeps_pins: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == qkc_pkg::FUNC_LOAD |=> $stable(prev_q))
		else $error("load beat altered pin history");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && result_valid_s2 && !result.ready |-> !sample.ready)
		else $error("input taken while both stages are full");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_s2 |-> sample.ready)
		else $error("input refused with an empty result stage");

endmodule

`default_nettype wire
